// ===== design/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, constants and codes of the split alignment fragment selector.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MAX_ALN  = 64;
  localparam int SLOT_W   = $clog2(MAX_ALN);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int POS_BITS = 31;
  localparam int ID_W     = 31;
  localparam int READ_W   = 24;
  localparam int SCORE_W  = 32;
  localparam int ACC_W    = 41;
  localparam int SUM_W    = 39;
  localparam int PROD_W   = SCORE_W + READ_W + 1;

  localparam logic [ACC_W-1:0]    ACC_CAP  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [READ_W-1:0]   READ_MAX = {READ_W{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX  = {POS_BITS{1'b1}};

  // CIGAR operation codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_MANY  = 2'd2;

  // configuration register indexes
  localparam logic CFG_LINK_MODE = 1'b0;
  localparam logic CFG_GAP_RATE  = 1'b1;
  localparam logic [7:0] GAP_RATE_RESET = 8'd77;

  typedef enum logic [2:0] {
    PH_LH, PH_LS, PH_CORE, PH_TS, PH_TH, PH_BAD
  } phase_e;

  typedef struct packed {
    logic [ACC_W-1:0] hl;
    logic [ACC_W-1:0] sl;
    logic [ACC_W-1:0] cr;
    logic [ACC_W-1:0] cf;
    logic [ACC_W-1:0] sr;
    phase_e           phase;
  } walk_t;

  localparam walk_t WALK_CLEAR = '{hl: '0, sl: '0, cr: '0, cf: '0, sr: '0, phase: PH_LH};

  typedef struct packed {
    logic [READ_W-1:0]         rd_from;
    logic [READ_W-1:0]         rd_to;
    logic [READ_W-1:0]         span_len;
    logic                      span_nz;
    logic [POS_BITS-1:0]       rf_from;
    logic [POS_BITS-1:0]       rf_to;
    logic [ID_W-1:0]           ref_id;
    logic signed [SCORE_W-1:0] score;
  } region_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FIN, S_DECIDE, S_ERR, S_SCAN_RD, S_SCAN_MUL, S_SCAN_CMP, S_PICK,
    S_LINK1, S_LINK2, S_CLASH_RD, S_CLASH_REG, S_CLASH_CMP, S_SEL_END,
    S_EM_START, S_EM_RD1, S_EM_RD2, S_EM_OUT, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_FIN, CMD_SEL_INIT, CMD_ERR_OUT, CMD_SCAN_RD, CMD_SCAN_MUL,
    CMD_SCAN_CMP, CMD_PICK, CMD_LINK1, CMD_LINK2, CMD_CLASH_RD, CMD_CLASH_REG,
    CMD_CLASH_CMP, CMD_CLASH_END, CMD_SEL_END, CMD_EM_RD1, CMD_EM_RD2,
    CMD_EM_OUT, CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    logic in_open;
    cmd_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic accept;
    logic ends_aln;
    logic last_aln;
    logic err;
    logic link_mode;
    logic scan_end;
    logic found;
    logic clash_end;
    logic n_zero;
    logic em_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/sfs_cigar.sv =====
// ----------------------------------------------------------------------------
// sfs_cigar
// CIGAR walker: tracks clip and core lengths and the grammar phase.
// ----------------------------------------------------------------------------
module sfs_cigar (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            clr_i,
  input  logic [3:0]      code_i,
  input  logic [27:0]     len_i,
  output sfs_pkg::walk_t  walk_o
);
  import sfs_pkg::*;

  walk_t walk_q, walk_d;

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [27:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + (ACC_W+1)'(b);
    sat_add = (s > {1'b0, ACC_CAP}) ? ACC_CAP : s[ACC_W-1:0];
  endfunction

  always_comb begin
    walk_d = walk_q;
    if (clr_i) begin
      walk_d = WALK_CLEAR;
    end else if (en_i && walk_q.phase != PH_BAD) begin
      if (code_i > OP_X) begin
        walk_d.phase = PH_BAD;
      end else if (code_i == OP_H) begin
        if (walk_q.phase == PH_LH) walk_d.hl = sat_add(walk_q.hl, len_i);
        else walk_d.phase = PH_TH;
      end else if (code_i == OP_S) begin
        case (walk_q.phase)
          PH_LH, PH_LS: begin
            walk_d.phase = PH_LS;
            walk_d.sl = sat_add(walk_q.sl, len_i);
          end
          PH_CORE, PH_TS: begin
            walk_d.phase = PH_TS;
            walk_d.sr = sat_add(walk_q.sr, len_i);
          end
          default: walk_d.phase = PH_BAD;
        endcase
      end else if (walk_q.phase == PH_TS || walk_q.phase == PH_TH) begin
        walk_d.phase = PH_BAD;
      end else begin
        walk_d.phase = PH_CORE;
        if (code_i == OP_M || code_i == OP_EQ || code_i == OP_X || code_i == OP_I) begin
          walk_d.cr = sat_add(walk_q.cr, len_i);
        end
        if (code_i == OP_M || code_i == OP_EQ || code_i == OP_X || code_i == OP_D ||
            code_i == OP_N) begin
          walk_d.cf = sat_add(walk_q.cf, len_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) walk_q <= WALK_CLEAR;
    else walk_q <= walk_d;
  end

  assign walk_o = walk_q;

endmodule

// ===== design/sfs_dp.sv =====
// ----------------------------------------------------------------------------
// sfs_dp
// Datapath: region store, selection loops, chain and cluster logic, output.
// ----------------------------------------------------------------------------
module sfs_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfs_pkg::ctrl_cmd_t                 cmd_i,
  output sfs_pkg::dp_stat_t                  stat_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               aln_mapped_i,
  input  logic [sfs_pkg::ID_W-1:0]           ref_index_i,
  input  logic [sfs_pkg::POS_BITS-1:0]       ref_start_i,
  input  logic [sfs_pkg::READ_W-1:0]         seq_length_i,
  input  logic signed [sfs_pkg::SCORE_W-1:0] aln_score_i,
  input  logic [3:0]                         op_code_i,
  input  logic [27:0]                        op_length_i,
  input  logic                               last_op_i,
  input  logic                               last_aln_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [sfs_pkg::SLOT_W-1:0]         aln_slot_o,
  output logic                               is_supplementary_o,
  output logic                               mate_valid_o,
  output logic [sfs_pkg::ID_W-1:0]           mate_ref_index_o,
  output logic [sfs_pkg::POS_BITS-1:0]       mate_ref_start_o,
  output logic                               last_result_o
);
  import sfs_pkg::*;

  function automatic logic ref_less(region_t a, region_t b);
    if (a.ref_id != b.ref_id) return a.ref_id < b.ref_id;
    if (a.rf_from != b.rf_from) return a.rf_from < b.rf_from;
    return a.rf_to < b.rf_to;
  endfunction

  function automatic logic overlap(region_t a, region_t b);
    return a.span_nz && b.span_nz && (a.rd_from < b.rd_to) && (b.rd_from < a.rd_to);
  endfunction

  logic accept, out_free, out_load;
  walk_t walk;

  // configuration
  logic       link_mode_q;
  logic [7:0] gap_rate_q;

  // item fields held for the alignment close
  logic                      mapped_q, last_aln_q;
  logic [ID_W-1:0]           ref_index_q;
  logic [POS_BITS-1:0]       ref_start_q;
  logic [READ_W-1:0]         seq_len_q;
  logic signed [SCORE_W-1:0] score_q;

  logic [CNT_W-1:0]   count_q;
  logic [1:0]         err_q;
  logic [MAX_ALN-1:0] mapped_vec_q, done_q;

  region_t            region_mem [MAX_ALN];
  logic [SLOT_W-1:0]  list_mem [MAX_ALN];
  region_t            rec_q, best_rec_q, pick_rec_q, prev_rec_q, new_rec;
  logic [SLOT_W-1:0]  list_a_q, list_b_q, best_idx_q, pick_idx_q;

  logic [CNT_W-1:0]   i_q, k_q, cur_lo_q, best_lo_q, best_hi_q, taken_q, j_q;
  logic [CNT_W-1:0]   n_q, base_q, e_q;
  logic               cand_q, found_q, have_q, clash_q, link_ok_q;
  logic signed [SUM_W-1:0]  sum_q, best_sum_q;
  logic signed [PROD_W-1:0] prod_c_q, prod_b_q;
  logic [31:0]        diff_q;
  logic [READ_W-1:0]  m_q;

  // alignment close arithmetic
  logic [ACC_W+1:0] hs_sum, end_sum, seq_sum;
  logic [ACC_W:0]   pend;
  logic             aln_bad, full;

  // chain step arithmetic
  logic [READ_W-1:0]   dr;
  logic [POS_BITS-1:0] df;
  logic [31:0]         dr_x, df_x;
  logic [39:0]         gap_lhs, gap_rhs;
  logic                linked, close_better, better;
  logic signed [SUM_W-1:0] pick_score;

  logic [CNT_W-1:0]  nx, a_idx, b_idx;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              rd_en, wr_en;

  sfs_cigar u_cigar (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .clr_i  (cmd_i.op == CMD_FIN),
    .code_i (op_code_i),
    .len_i  (op_length_i),
    .walk_o (walk)
  );

  assign accept   = in_valid_i & cmd_i.in_open;
  assign out_free = ~out_valid_o | ~out_stall_i;
  assign out_load = out_free & ((cmd_i.op == CMD_EM_OUT) | (cmd_i.op == CMD_ERR_OUT));
  assign full     = count_q >= CNT_W'(MAX_ALN);

  always_comb begin
    hs_sum  = (ACC_W+2)'(walk.hl) + (ACC_W+2)'(walk.sl);
    end_sum = hs_sum + (ACC_W+2)'(walk.cr);
    seq_sum = (ACC_W+2)'(walk.sl) + (ACC_W+2)'(walk.cr) + (ACC_W+2)'(walk.sr);
    aln_bad = (walk.phase == PH_BAD) || (seq_sum != (ACC_W+2)'(seq_len_q)) ||
              (end_sum > (ACC_W+2)'(READ_MAX));
    pend    = (ACC_W+1)'(ref_start_q) + (ACC_W+1)'(walk.cf);
    new_rec.rd_from  = hs_sum[READ_W-1:0];
    new_rec.rd_to    = end_sum[READ_W-1:0];
    new_rec.span_nz  = walk.cr != '0;
    new_rec.span_len = (walk.cr != '0) ? walk.cr[READ_W-1:0] : READ_W'(1);
    new_rec.rf_from  = ref_start_q;
    new_rec.rf_to    = (pend > (ACC_W+1)'(POS_MAX)) ? POS_MAX : pend[POS_BITS-1:0];
    new_rec.ref_id   = ref_index_q;
    new_rec.score    = score_q;
  end

  always_comb begin
    dr      = pick_rec_q.rd_from - prev_rec_q.rd_to;
    df      = pick_rec_q.rf_from - prev_rec_q.rf_to;
    dr_x    = 32'(dr);
    df_x    = 32'(df);
    gap_lhs = {diff_q, 8'd0};
    gap_rhs = 40'({1'b0, gap_rate_q} + 9'd256) * 40'(m_q);
    linked  = (k_q != '0) && link_ok_q && (gap_lhs <= gap_rhs);
    pick_score   = {{(SUM_W-SCORE_W){pick_rec_q.score[SCORE_W-1]}}, pick_rec_q.score};
    close_better = !have_q || (sum_q > best_sum_q);
    better       = link_mode_q ? (prod_c_q > prod_b_q) : ref_less(rec_q, best_rec_q);
    nx    = (e_q + CNT_W'(1) == n_q) ? '0 : e_q + CNT_W'(1);
    a_idx = base_q + e_q;
    b_idx = base_q + nx;
  end

  // region store port select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = i_q[SLOT_W-1:0];
    case (cmd_i.op)
      CMD_SCAN_RD:   rd_addr = i_q[SLOT_W-1:0];
      CMD_CLASH_REG: rd_addr = list_a_q;
      CMD_EM_RD2:    rd_addr = list_b_q;
      default:       rd_en = 1'b0;
    endcase
    wr_en   = 1'b0;
    wr_addr = k_q[SLOT_W-1:0];
    case (cmd_i.op)
      CMD_PICK: wr_en = ~link_mode_q;
      CMD_CLASH_END: begin
        wr_en   = ~clash_q;
        wr_addr = taken_q[SLOT_W-1:0];
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_FIN && !full && mapped_q && !aln_bad) begin
      region_mem[count_q[SLOT_W-1:0]] <= new_rec;
    end
    if (rd_en) rec_q <= region_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) list_mem[wr_addr] <= (cmd_i.op == CMD_PICK) ? best_idx_q : pick_idx_q;
    if (cmd_i.op == CMD_CLASH_RD) list_a_q <= list_mem[j_q[SLOT_W-1:0]];
    if (cmd_i.op == CMD_EM_RD1) begin
      list_a_q <= list_mem[a_idx[SLOT_W-1:0]];
      list_b_q <= list_mem[b_idx[SLOT_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mapped_q    <= aln_mapped_i;
      ref_index_q <= ref_index_i;
      ref_start_q <= ref_start_i;
      seq_len_q   <= seq_length_i;
      score_q     <= aln_score_i;
    end
    case (cmd_i.op)
      CMD_FIN: mapped_vec_q[count_q[SLOT_W-1:0]] <= mapped_q & ~aln_bad & ~full;
      CMD_SCAN_MUL: begin
        prod_c_q <= $signed(rec_q.score) * $signed({1'b0, best_rec_q.span_len});
        prod_b_q <= $signed(best_rec_q.score) * $signed({1'b0, rec_q.span_len});
      end
      CMD_SCAN_CMP: begin
        if (cand_q && (!found_q || better)) begin
          best_rec_q <= rec_q;
          best_idx_q <= i_q[SLOT_W-1:0];
        end
      end
      CMD_PICK: begin
        pick_rec_q <= best_rec_q;
        pick_idx_q <= best_idx_q;
      end
      CMD_LINK1: begin
        link_ok_q <= (prev_rec_q.ref_id == pick_rec_q.ref_id) &&
                     (pick_rec_q.rd_from >= prev_rec_q.rd_to) &&
                     (pick_rec_q.rf_from >= prev_rec_q.rf_to);
        diff_q <= (dr_x > df_x) ? dr_x - df_x : df_x - dr_x;
        m_q    <= (dr_x < df_x) ? dr : df[READ_W-1:0];
      end
      CMD_LINK2: prev_rec_q <= pick_rec_q;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_mode_q <= 1'b0;
      gap_rate_q  <= GAP_RATE_RESET;
      last_aln_q  <= 1'b0;
      count_q     <= '0;
      err_q       <= '0;
      done_q      <= '0;
      i_q <= '0; k_q <= '0; cur_lo_q <= '0; best_lo_q <= '0; best_hi_q <= '0;
      taken_q <= '0; j_q <= '0; n_q <= '0; base_q <= '0; e_q <= '0;
      cand_q <= 1'b0; found_q <= 1'b0; have_q <= 1'b0; clash_q <= 1'b0;
      sum_q <= '0; best_sum_q <= '0;
      out_valid_o <= 1'b0;
      status_o <= ST_OK; aln_slot_o <= '0; is_supplementary_o <= 1'b0;
      mate_valid_o <= 1'b0; mate_ref_index_o <= '0; mate_ref_start_o <= '0;
      last_result_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LINK_MODE: link_mode_q <= cfg_data_i[0];
          CFG_GAP_RATE:  gap_rate_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) last_aln_q <= last_aln_i;
      // load a new word, or drop the one the receiver just took
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;

      case (cmd_i.op)
        CMD_FIN: begin
          if (full) begin
            err_q[1] <= 1'b1;
          end else begin
            count_q <= count_q + CNT_W'(1);
            if (mapped_q && aln_bad) err_q[0] <= 1'b1;
          end
        end
        CMD_SEL_INIT: begin
          done_q <= '0;
          i_q <= '0; k_q <= '0; cur_lo_q <= '0; best_lo_q <= '0; best_hi_q <= '0;
          taken_q <= '0; found_q <= 1'b0; have_q <= 1'b0;
          sum_q <= '0; best_sum_q <= '0;
        end
        CMD_SCAN_RD: begin
          cand_q <= (i_q < count_q) && mapped_vec_q[i_q[SLOT_W-1:0]] &&
                    !done_q[i_q[SLOT_W-1:0]];
        end
        CMD_SCAN_CMP: begin
          if (cand_q) found_q <= 1'b1;
          i_q <= i_q + CNT_W'(1);
        end
        CMD_PICK: begin
          done_q[best_idx_q] <= 1'b1;
          i_q     <= '0;
          found_q <= 1'b0;
          j_q     <= '0;
          clash_q <= 1'b0;
        end
        CMD_LINK2: begin
          if (linked) begin
            sum_q <= sum_q + pick_score;
          end else begin
            if (k_q != '0 && close_better) begin
              best_sum_q <= sum_q;
              best_lo_q  <= cur_lo_q;
              best_hi_q  <= k_q;
              have_q     <= 1'b1;
            end
            cur_lo_q <= k_q;
            sum_q    <= pick_score;
          end
          k_q <= k_q + CNT_W'(1);
        end
        CMD_CLASH_CMP: begin
          if (overlap(pick_rec_q, rec_q)) clash_q <= 1'b1;
          j_q <= j_q + CNT_W'(1);
        end
        CMD_CLASH_END: begin
          if (!clash_q) taken_q <= taken_q + CNT_W'(1);
        end
        CMD_SEL_END: begin
          e_q <= '0;
          if (link_mode_q) begin
            n_q    <= taken_q;
            base_q <= '0;
          end else if (k_q != '0 && close_better) begin
            n_q    <= k_q - cur_lo_q;
            base_q <= cur_lo_q;
          end else begin
            n_q    <= best_hi_q - best_lo_q;
            base_q <= best_lo_q;
          end
        end
        CMD_ERR_OUT: begin
          if (out_free) begin
            status_o <= err_q[0] ? ST_MALFORMED : ST_TOO_MANY;
            aln_slot_o <= '0; is_supplementary_o <= 1'b0; mate_valid_o <= 1'b0;
            mate_ref_index_o <= '0; mate_ref_start_o <= '0;
            last_result_o <= 1'b1;
          end
        end
        CMD_EM_OUT: begin
          if (out_free) begin
            status_o           <= ST_OK;
            aln_slot_o         <= list_a_q;
            is_supplementary_o <= e_q != '0;
            mate_valid_o       <= n_q > CNT_W'(1);
            mate_ref_index_o   <= (n_q > CNT_W'(1)) ? rec_q.ref_id : '0;
            mate_ref_start_o   <= (n_q > CNT_W'(1)) ? rec_q.rf_from : '0;
            last_result_o      <= e_q + CNT_W'(1) == n_q;
            e_q                <= e_q + CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          count_q <= '0;
          err_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.accept    = accept;
    stat_o.ends_aln  = last_op_i | last_aln_i;
    stat_o.last_aln  = last_aln_q;
    stat_o.err       = err_q != '0;
    stat_o.link_mode = link_mode_q;
    stat_o.scan_end  = i_q == count_q;
    stat_o.found     = found_q;
    stat_o.clash_end = (j_q == taken_q) || clash_q;
    stat_o.n_zero    = n_q == '0;
    stat_o.em_last   = e_q + CNT_W'(1) == n_q;
    stat_o.out_free  = out_free;
  end

endmodule

// ===== design/sfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfs_ctrl
// Controller: sequences loading, selection loops and result emission.
// ----------------------------------------------------------------------------
module sfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfs_pkg::dp_stat_t   stat_i,
  output sfs_pkg::ctrl_cmd_t  cmd_o
);
  import sfs_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (stat_i.accept && stat_i.ends_aln) state_d = S_FIN;
      S_FIN:       state_d = stat_i.last_aln ? S_DECIDE : S_IDLE;
      S_DECIDE:    state_d = stat_i.err ? S_ERR : S_SCAN_RD;
      S_ERR:       if (stat_i.out_free) state_d = S_DONE;
      S_SCAN_RD: begin
        if (!stat_i.scan_end) state_d = S_SCAN_MUL;
        else state_d = stat_i.found ? S_PICK : S_SEL_END;
      end
      S_SCAN_MUL:  state_d = S_SCAN_CMP;
      S_SCAN_CMP:  state_d = S_SCAN_RD;
      S_PICK:      state_d = stat_i.link_mode ? S_CLASH_RD : S_LINK1;
      S_LINK1:     state_d = S_LINK2;
      S_LINK2:     state_d = S_SCAN_RD;
      S_CLASH_RD:  state_d = stat_i.clash_end ? S_SCAN_RD : S_CLASH_REG;
      S_CLASH_REG: state_d = S_CLASH_CMP;
      S_CLASH_CMP: state_d = S_CLASH_RD;
      S_SEL_END:   state_d = S_EM_START;
      S_EM_START:  state_d = stat_i.n_zero ? S_DONE : S_EM_RD1;
      S_EM_RD1:    state_d = S_EM_RD2;
      S_EM_RD2:    state_d = S_EM_OUT;
      S_EM_OUT:    if (stat_i.out_free) state_d = stat_i.em_last ? S_DONE : S_EM_RD1;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.in_open = 1'b0;
    cmd_o.op      = CMD_NONE;
    case (state_q)
      S_IDLE:      cmd_o.in_open = 1'b1;
      S_FIN:       cmd_o.op = CMD_FIN;
      S_DECIDE:    cmd_o.op = stat_i.err ? CMD_NONE : CMD_SEL_INIT;
      S_ERR:       cmd_o.op = CMD_ERR_OUT;
      S_SCAN_RD:   cmd_o.op = CMD_SCAN_RD;
      S_SCAN_MUL:  cmd_o.op = CMD_SCAN_MUL;
      S_SCAN_CMP:  cmd_o.op = CMD_SCAN_CMP;
      S_PICK:      cmd_o.op = CMD_PICK;
      S_LINK1:     cmd_o.op = CMD_LINK1;
      S_LINK2:     cmd_o.op = CMD_LINK2;
      S_CLASH_RD:  cmd_o.op = stat_i.clash_end ? CMD_CLASH_END : CMD_CLASH_RD;
      S_CLASH_REG: cmd_o.op = CMD_CLASH_REG;
      S_CLASH_CMP: cmd_o.op = CMD_CLASH_CMP;
      S_SEL_END:   cmd_o.op = CMD_SEL_END;
      S_EM_RD1:    cmd_o.op = CMD_EM_RD1;
      S_EM_RD2:    cmd_o.op = CMD_EM_RD2;
      S_EM_OUT:    cmd_o.op = CMD_EM_OUT;
      S_DONE:      cmd_o.op = CMD_CLEAR;
      default:     cmd_o.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// ===== design/split_alignment_fragment_selector.sv =====
// ----------------------------------------------------------------------------
// split_alignment_fragment_selector
// Picks the split-alignment fragments of one read and emits them with mate
// and supplementary fields.
// ----------------------------------------------------------------------------
// Feed the alignments of a read one CIGAR operation per word; the per-
// alignment fields are taken from the word that ends the alignment (last_op
// or last_aln). Words are taken only in the load state; after the word that
// ends an alignment the block stops taking words while it stores the region,
// and after the word with last_aln while it selects and emits. Selection
// walks the region store through its single read port: each pass reads,
// multiplies and compares every stored alignment in turn, and there is one
// pass per mapped alignment plus one; cluster mode adds an overlap check
// (list read, store read, compare) against each already kept fragment.
// Emission reads the list, then the store, then loads each result word. A
// finished result waits in the output register, so the next read may start
// loading while it is held.
// ----------------------------------------------------------------------------
module split_alignment_fragment_selector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [7:0]                         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               aln_mapped_i,
  input  logic [sfs_pkg::ID_W-1:0]           ref_index_i,
  input  logic [sfs_pkg::POS_BITS-1:0]       ref_start_i,
  input  logic [sfs_pkg::READ_W-1:0]         seq_length_i,
  input  logic signed [sfs_pkg::SCORE_W-1:0] aln_score_i,
  input  logic [3:0]                         op_code_i,
  input  logic [27:0]                        op_length_i,
  input  logic                               last_op_i,
  input  logic                               last_aln_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [sfs_pkg::SLOT_W-1:0]         aln_slot_o,
  output logic                               is_supplementary_o,
  output logic                               mate_valid_o,
  output logic [sfs_pkg::ID_W-1:0]           mate_ref_index_o,
  output logic [sfs_pkg::POS_BITS-1:0]       mate_ref_start_o,
  output logic                               last_result_o
);
  import sfs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // words are taken only while the controller waits in its load state
  assign in_stall_o = ~cmd.in_open;

  sfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sfs_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .aln_mapped_i       (aln_mapped_i),
    .ref_index_i        (ref_index_i),
    .ref_start_i        (ref_start_i),
    .seq_length_i       (seq_length_i),
    .aln_score_i        (aln_score_i),
    .op_code_i          (op_code_i),
    .op_length_i        (op_length_i),
    .last_op_i          (last_op_i),
    .last_aln_i         (last_aln_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .aln_slot_o         (aln_slot_o),
    .is_supplementary_o (is_supplementary_o),
    .mate_valid_o       (mate_valid_o),
    .mate_ref_index_o   (mate_ref_index_o),
    .mate_ref_start_o   (mate_ref_start_o),
    .last_result_o      (last_result_o)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for split_alignment_fragment_selector. Each accepted
// CIGAR word runs through a behavioral fragment picker that keeps its own
// region store and configuration. The resulting fragment words are queued
// and then compared field by field with the block's output words. The
// stimulus has directed corner reads, an overfull read, a full store, a
// long output hold and random colinear reads with noise under several
// link settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sfs_pkg::*;

  localparam int          WATCHDOG_LIMIT = 200000;
  localparam int          HOLD_CYCLES    = 600;
  localparam longint unsigned WALK_CAP   = 64'd1 << 40;
  localparam longint unsigned RD_MAX     = 64'hFF_FFFF;
  localparam longint unsigned RF_MAX     = 64'h7FFF_FFFF;

  typedef struct {
    bit        mapped;
    bit [30:0] ref_id;
    bit [30:0] start;
    bit [23:0] seqlen;
    bit [31:0] score;
    bit [3:0]  code;
    bit [27:0] len;
    bit        last_op;
    bit        last_aln;
  } cigar_word_t;

  typedef struct {
    bit [1:0]  status;
    bit [5:0]  slot;
    bit        supp;
    bit        mate_ok;
    bit [30:0] mate_ref;
    bit [30:0] mate_start;
    bit        last;
  } frag_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        aln_mapped_i = 1'b0;
  logic [30:0] ref_index_i = '0;
  logic [30:0] ref_start_i = '0;
  logic [23:0] seq_length_i = '0;
  logic signed [31:0] aln_score_i = '0;
  logic [3:0]  op_code_i = '0;
  logic [27:0] op_length_i = '0;
  logic        last_op_i = 1'b0;
  logic        last_aln_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  aln_slot_o;
  logic        is_supplementary_o;
  logic        mate_valid_o;
  logic [30:0] mate_ref_index_o;
  logic [30:0] mate_ref_start_o;
  logic        last_result_o;

  split_alignment_fragment_selector DUT (.*);

  always #4 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Fragment picker: CIGAR walk, region store and per-read selection
  // ------------------------------------------------------------------------
  bit              pick_mode;
  bit [7:0]        pick_gap_rate = GAP_RATE_RESET;
  longint unsigned walk_hl, walk_sl, walk_cr, walk_cf, walk_sr;
  phase_e          walk_phase = PH_LH;
  longint unsigned rg_rd_from[64], rg_rd_to[64], rg_rf_from[64], rg_rf_to[64];
  bit [30:0]       rg_ref[64];
  longint          rg_score[64];
  bit              rg_mapped[64];
  int              rg_count;
  bit [1:0]        read_errs;
  int              picked[64];
  frag_word_t      expected_frags[$];
  int              errors;

  function automatic longint unsigned capped_sum(longint unsigned a, longint unsigned b);
    return (a + b > WALK_CAP) ? WALK_CAP : a + b;
  endfunction

  function automatic void walk_clear();
    walk_hl = 0; walk_sl = 0; walk_cr = 0; walk_cf = 0; walk_sr = 0;
    walk_phase = PH_LH;
  endfunction

  function automatic void walk_cigar(bit [3:0] code, longint unsigned len);
    if (walk_phase == PH_BAD) return;
    if (code > OP_X) begin
      walk_phase = PH_BAD;
    end else if (code == OP_H) begin
      if (walk_phase == PH_LH) walk_hl = capped_sum(walk_hl, len);
      else walk_phase = PH_TH;
    end else if (code == OP_S) begin
      if (walk_phase == PH_LH || walk_phase == PH_LS) begin
        walk_phase = PH_LS;
        walk_sl = capped_sum(walk_sl, len);
      end else if (walk_phase == PH_CORE || walk_phase == PH_TS) begin
        walk_phase = PH_TS;
        walk_sr = capped_sum(walk_sr, len);
      end else begin
        walk_phase = PH_BAD;
      end
    end else begin
      if (walk_phase == PH_TS || walk_phase == PH_TH) begin
        walk_phase = PH_BAD;
        return;
      end
      walk_phase = PH_CORE;
      if (code inside {OP_M, OP_EQ, OP_X, OP_I}) walk_cr = capped_sum(walk_cr, len);
      if (code inside {OP_M, OP_EQ, OP_X, OP_D, OP_N}) walk_cf = capped_sum(walk_cf, len);
    end
  endfunction

  function automatic void close_alignment(cigar_word_t w);
    int s;
    longint unsigned rf_end;
    s = rg_count;
    if (s >= MAX_ALN) begin
      read_errs[1] = 1'b1;
      walk_clear();
      return;
    end
    rg_count++;
    rg_mapped[s] = 1'b0;
    if (w.mapped) begin
      if (walk_phase == PH_BAD || walk_sl + walk_cr + walk_sr != w.seqlen ||
          walk_hl + walk_sl + walk_cr > RD_MAX) begin
        read_errs[0] = 1'b1;
      end else begin
        rf_end = w.start + walk_cf;
        rg_rd_from[s] = walk_hl + walk_sl;
        rg_rd_to[s]   = walk_hl + walk_sl + walk_cr;
        rg_rf_from[s] = w.start;
        rg_rf_to[s]   = (rf_end > RF_MAX) ? RF_MAX : rf_end;
        rg_ref[s]     = w.ref_id;
        rg_score[s]   = longint'($signed(w.score));
        rg_mapped[s]  = 1'b1;
      end
    end
    walk_clear();
  endfunction

  function automatic bit ref_order_less(int a, int b);
    if (rg_ref[a] != rg_ref[b]) return rg_ref[a] < rg_ref[b];
    if (rg_rf_from[a] != rg_rf_from[b]) return rg_rf_from[a] < rg_rf_from[b];
    return rg_rf_to[a] < rg_rf_to[b];
  endfunction

  function automatic bit gap_ok(int p, int c);
    longint unsigned dr, df, diff, m;
    if (rg_ref[p] != rg_ref[c]) return 1'b0;
    if (rg_rd_from[c] < rg_rd_to[p] || rg_rf_from[c] < rg_rf_to[p]) return 1'b0;
    dr = rg_rd_from[c] - rg_rd_to[p];
    df = rg_rf_from[c] - rg_rf_to[p];
    diff = (dr > df) ? dr - df : df - dr;
    m = (dr < df) ? dr : df;
    return diff * 256 <= (256 + longint'(pick_gap_rate)) * m;
  endfunction

  function automatic int pick_chain();
    int order[64];
    int n, i, j, lo, hi, best_lo, best_hi;
    longint best, total;
    bit have;
    n = 0; best_lo = 0; best_hi = 0; best = 0; have = 0;
    for (i = 0; i < rg_count; i++) begin
      if (!rg_mapped[i]) continue;
      j = n;
      while (j > 0 && ref_order_less(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      n++;
    end
    i = 0;
    while (i < n) begin
      lo = i;
      hi = i + 1;
      while (hi < n && gap_ok(order[hi-1], order[hi])) hi++;
      total = 0;
      for (j = lo; j < hi; j++) total += rg_score[order[j]];
      if (!have || total > best) begin
        have = 1; best = total; best_lo = lo; best_hi = hi;
      end
      i = hi;
    end
    for (j = best_lo; j < best_hi; j++) picked[j-best_lo] = order[j];
    return best_hi - best_lo;
  endfunction

  function automatic longint read_span(int s);
    longint unsigned l;
    l = (rg_rd_to[s] > rg_rd_from[s]) ? rg_rd_to[s] - rg_rd_from[s] : 0;
    return (l == 0) ? 1 : longint'(l);
  endfunction

  function automatic bit spans_overlap(int a, int b);
    if (rg_rd_to[a] <= rg_rd_from[a] || rg_rd_to[b] <= rg_rd_from[b]) return 1'b0;
    return rg_rd_from[a] < rg_rd_to[b] && rg_rd_from[b] < rg_rd_to[a];
  endfunction

  function automatic int pick_cluster();
    bit done[64];
    int i, k, best, taken;
    bit found, clash;
    taken = 0;
    for (i = 0; i < 64; i++) done[i] = (i >= rg_count) || !rg_mapped[i];
    forever begin
      found = 0;
      best = 0;
      for (i = 0; i < rg_count; i++) begin
        if (done[i]) continue;
        if (!found || rg_score[i] * read_span(best) > rg_score[best] * read_span(i)) begin
          best = i;
          found = 1;
        end
      end
      if (!found) break;
      done[best] = 1;
      clash = 0;
      for (k = 0; k < taken; k++) if (spans_overlap(best, picked[k])) clash = 1;
      if (!clash) picked[taken++] = best;
    end
    return taken;
  endfunction

  function automatic void close_read();
    frag_word_t f;
    int n, k, nx;
    if (read_errs != 0) begin
      f = '{default: 0};
      f.status = read_errs[0] ? ST_MALFORMED : ST_TOO_MANY;
      f.last = 1;
      expected_frags = {expected_frags, f};
    end else begin
      n = pick_mode ? pick_cluster() : pick_chain();
      for (k = 0; k < n; k++) begin
        nx = picked[(k + 1) % n];
        f.status     = ST_OK;
        f.slot       = picked[k][5:0];
        f.supp       = (k > 0);
        f.mate_ok    = (n > 1);
        f.mate_ref   = (n > 1) ? rg_ref[nx] : '0;
        f.mate_start = (n > 1) ? rg_rf_from[nx][30:0] : '0;
        f.last       = (k + 1 == n);
        expected_frags = {expected_frags, f};
      end
    end
    rg_count = 0;
    read_errs = 0;
    walk_clear();
  endfunction

  // Track configuration writes and accepted words.
  always @(posedge clk_i) begin
    cigar_word_t w;
    if (cfg_we_i) begin
      if (cfg_index_i == CFG_LINK_MODE) pick_mode = cfg_data_i[0];
      else pick_gap_rate = cfg_data_i;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      w = '{aln_mapped_i, ref_index_i, ref_start_i, seq_length_i, aln_score_i,
            op_code_i, op_length_i, last_op_i, last_aln_i};
      walk_cigar(w.code, 64'(w.len));
      if (w.last_op || w.last_aln) close_alignment(w);
      if (w.last_aln) close_read();
    end
  end

  // ------------------------------------------------------------------------
  // Output check
  // ------------------------------------------------------------------------
  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    frag_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frags.size() == 0) begin
        $display("%0t: unexpected word, expected none actual slot %0h status %0h",
                 $time, aln_slot_o, status_o);
        errors++;
      end else begin
        e = expected_frags.pop_front();
        check_field("status", 64'(e.status), 64'(status_o));
        check_field("aln_slot", 64'(e.slot), 64'(aln_slot_o));
        check_field("is_supplementary", 64'(e.supp), 64'(is_supplementary_o));
        check_field("mate_valid", 64'(e.mate_ok), 64'(mate_valid_o));
        check_field("mate_ref_index", 64'(e.mate_ref), 64'(mate_ref_index_o));
        check_field("mate_ref_start", 64'(e.mate_start), 64'(mate_ref_start_o));
        check_field("last_result", 64'(e.last), 64'(last_result_o));
      end
    end
  end

  // Watchdog: count cycles with no handshake on any port.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: the stall pattern is redrawn at random from four modes; a hold
  // request stalls the output for a long stretch.
  // ------------------------------------------------------------------------
  bit hold_req;
  initial begin
    int mode, tick;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= (tick % 5 < 3);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------------
  int        burst_left;
  bit        sender_gaps = 1;
  int        words_sent;
  int        read_alns;
  int        last_read_alns;
  bit [3:0]  op_codes[$];
  bit [27:0] op_lens[$];

  task automatic send_word(cigar_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    aln_mapped_i <= w.mapped;
    ref_index_i  <= w.ref_id;
    ref_start_i  <= w.start;
    seq_length_i <= w.seqlen;
    aln_score_i  <= w.score;
    op_code_i    <= w.code;
    op_length_i  <= w.len;
    last_op_i    <= w.last_op;
    last_aln_i   <= w.last_aln;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic add_op(bit [3:0] code, bit [27:0] len);
    op_codes = {op_codes, code};
    op_lens  = {op_lens, len};
  endtask

  // Send the queued ops as one alignment; seqlen is the stored read length
  // of the ops plus a skew. Drop last_op on the final word of a read when asked.
  task automatic send_alignment(bit mapped, bit [30:0] rid, bit [30:0] rstart,
                                bit [31:0] score, int skew, bit end_read,
                                bit drop_last_op = 0);
    cigar_word_t w;
    longint unsigned rl;
    rl = 0;
    foreach (op_codes[i])
      if (op_codes[i] inside {OP_M, OP_I, OP_S, OP_EQ, OP_X}) rl += op_lens[i];
    w.mapped = mapped; w.ref_id = rid; w.start = rstart; w.score = score;
    w.seqlen = 24'(rl + skew);
    foreach (op_codes[i]) begin
      w.code = op_codes[i];
      w.len = op_lens[i];
      w.last_op = (i == op_codes.size() - 1) && !(end_read && drop_last_op);
      w.last_aln = (i == op_codes.size() - 1) && end_read;
      send_word(w);
    end
    op_codes.delete();
    op_lens.delete();
    read_alns++;
    if (end_read) begin
      last_read_alns = read_alns;
      read_alns = 0;
    end
  endtask

  // Queue a well-formed CIGAR: clips around a core of mixed ops.
  task automatic queue_frag(int hl, int sl, int core, int sr, int hr);
    int m1;
    if (hl > 0) add_op(OP_H, 28'(hl));
    if (sl > 0) add_op(OP_S, 28'(sl));
    m1 = $urandom_range(1, core);
    add_op(($urandom_range(0, 2) == 0) ? OP_EQ : OP_M, 28'(m1));
    if ($urandom_range(0, 2) == 0) add_op(($urandom_range(0, 1) == 1) ? OP_D : OP_N,
                                          28'($urandom_range(1, 4)));
    if ($urandom_range(0, 5) == 0) add_op(OP_P, 28'($urandom_range(0, 2)));
    if (core > m1) add_op(($urandom_range(0, 1) == 1) ? OP_I : OP_X, 28'(core - m1));
    if (sr > 0) add_op(OP_S, 28'(sr));
    if (hr > 0) add_op(OP_H, 28'(hr));
  endtask

  task automatic set_reg(logic idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain: wait for every expected word, then for the selection time of the
  // last read, which may produce no word at all.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_frags.size() != 0) @(posedge clk_i);
    repeat (3 * last_read_alns * (last_read_alns + 1) + 300) @(posedge clk_i);
  endtask

  task automatic noise_ops();
    int k;
    k = $urandom_range(1, 4);
    repeat (k) add_op(4'($urandom_range(0, 15)),
                      28'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 50)));
  endtask

  // One random read: colinear fragments with random gaps, overlaps and
  // jitter, sent in random order, with an occasional noisy alignment.
  task automatic random_read();
    int nal, q, tot, k, p, t, lead, tail, jit;
    int f_q[8], f_len[8], f_jit[8], order[8];
    bit [30:0] base, rid;
    nal = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    base = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 5000));
    rid  = ($urandom_range(0, 4) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 3));
    q = 0;
    for (k = 0; k < nal; k++) begin
      f_q[k] = q;
      f_len[k] = $urandom_range(4, 40);
      f_jit[k] = $urandom_range(0, 8);
      order[k] = k;
      if ($urandom_range(0, 4) == 0) q += f_len[k] - $urandom_range(1, 3);
      else q += f_len[k] + $urandom_range(0, 12);
    end
    tot = q + $urandom_range(0, 10);
    for (k = nal - 1; k > 0; k--) begin
      p = $urandom_range(0, k);
      t = order[k]; order[k] = order[p]; order[p] = t;
    end
    for (k = 0; k < nal; k++) begin
      p = order[k];
      case ($urandom_range(0, 11))
        0: begin
          noise_ops();
          send_alignment(0, 31'($urandom()), 31'($urandom()), $urandom(), 0, k == nal - 1);
        end
        1: begin
          noise_ops();
          send_alignment(1, rid, base, $urandom(), $urandom_range(0, 1), k == nal - 1);
        end
        default: begin
          lead = $urandom_range(0, f_q[p]);
          tail = tot - f_q[p] - f_len[p];
          if (tail < 0) tail = 0;
          t = $urandom_range(0, tail);
          queue_frag(lead, f_q[p] - lead, f_len[p], tail - t, t);
          jit = ($urandom_range(0, 9) == 0) ? 1 : 0;
          send_alignment(1, ($urandom_range(0, 7) == 0) ? 31'(rid + 31'd1) : rid,
                         31'(base + 31'(f_q[p]) + 31'(f_jit[p])),
                         ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 200),
                         jit, k == nal - 1, $urandom_range(0, 9) == 0);
        end
      endcase
    end
  endtask

  task automatic random_reads(int target);
    int start_count;
    start_count = words_sent;
    while (words_sent - start_count < target) random_read();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_corner_reads();
    add_op(OP_M, 10);
    send_alignment(1, 0, 0, 5, 0, 1);
    // every op code, clips on both ends
    add_op(OP_H, 3); add_op(OP_S, 2); add_op(OP_M, 4); add_op(OP_I, 1); add_op(OP_EQ, 2);
    add_op(OP_X, 1); add_op(OP_D, 3); add_op(OP_N, 2); add_op(OP_P, 1); add_op(OP_S, 2);
    add_op(OP_H, 1);
    send_alignment(1, 31'h7FFF_FFFF, 31'h2A, 32'h7FFF_FFFF, 0, 0);
    add_op(OP_M, 6);
    send_alignment(1, 31'h7FFF_FFFF, 31'h100, 32'h8000_0000, 0, 1);
    // soft clip inside the core
    add_op(OP_M, 5); add_op(OP_S, 2); add_op(OP_M, 3);
    send_alignment(1, 1, 10, 7, 0, 1);
    // op codes above X
    add_op(OP_M, 2); add_op(4'hF, 1);
    send_alignment(1, 1, 10, 7, 0, 1);
    add_op(4'd9, 28'hFFF_FFFF);
    send_alignment(1, 1, 10, 7, 0, 1);
    // widest read span that still fits, then one that overflows
    add_op(OP_M, 28'hFF_FFFF);
    send_alignment(1, 2, 31'h7FFF_FF00, 1, 0, 1);
    add_op(OP_H, 1); add_op(OP_M, 28'hFF_FFFF);
    send_alignment(1, 2, 0, 1, 0, 1);
    // reference end saturates
    add_op(OP_M, 1); add_op(OP_D, 28'hFFF_FFFF);
    send_alignment(1, 3, 31'h7FFF_FFF0, 9, 0, 1);
    // zero read span beside a normal fragment
    add_op(OP_S, 4); add_op(OP_D, 5);
    send_alignment(1, 3, 50, 100, 0, 0);
    add_op(OP_M, 8);
    send_alignment(1, 3, 60, 3, 0, 1);
    // S after trailing H, core after trailing S
    add_op(OP_M, 3); add_op(OP_H, 2); add_op(OP_S, 1);
    send_alignment(1, 4, 0, 1, 0, 1);
    add_op(OP_M, 2); add_op(OP_S, 1); add_op(OP_M, 1);
    send_alignment(1, 4, 0, 1, 0, 1);
    // unmapped only: no word comes out
    add_op(OP_S, 7);
    send_alignment(0, 0, 0, 0, 3, 1);
    // wrong length, and last_aln without last_op
    add_op(OP_M, 5);
    send_alignment(1, 5, 5, 1, 1, 1);
    add_op(OP_H, 2); add_op(OP_M, 9);
    send_alignment(0, 5, 5, 1, 0, 0);
    add_op(OP_S, 1); add_op(OP_M, 9);
    send_alignment(1, 5, 20, 4, 0, 1, 1);
  endtask

  task automatic test_too_many();
    for (int k = 0; k <= MAX_ALN; k++) begin
      add_op(OP_M, 1);
      send_alignment(1, 0, 31'(k), 32'(k), 0, k == MAX_ALN);
    end
  endtask

  task automatic test_full_store();
    for (int k = 0; k < MAX_ALN; k++) begin
      if (k % 4 == 0) add_op(OP_H, 28'(2 * k));
      add_op(OP_M, 3);
      send_alignment(k % 7 != 3, 31'(k % 3), 31'(40 * k), $urandom_range(0, 300), 0,
                     k == MAX_ALN - 1);
    end
  endtask

  task automatic test_output_hold();
    hold_req = 1;
    sender_gaps = 0;
    repeat (3) random_read();
    sender_gaps = 1;
  endtask

  initial begin
    errors = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_reads();
    test_too_many();
    wait_drained();

    set_reg(CFG_GAP_RATE, 8'd0);
    random_reads(20);
    wait_drained();

    set_reg(CFG_GAP_RATE, 8'd255);
    sender_gaps = 0;
    random_reads(20);
    sender_gaps = 1;
    wait_drained();

    set_reg(CFG_LINK_MODE, 8'd1);
    set_reg(CFG_GAP_RATE, GAP_RATE_RESET);
    random_reads(20);
    test_full_store();
    test_output_hold();
    wait_drained();

    set_reg(CFG_LINK_MODE, 8'd0);
    set_reg(CFG_GAP_RATE, 8'd200);
    random_reads(20);
    wait_drained();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
